@@ rtl/ccd_pkg.sv @@
// Shared types and constants for the controller change event detector.
package ccd_pkg;

  localparam int VALUE_W       = 16;   // Q1.15 axis value width
  localparam int MASK_W        = 16;   // width of the button mask field
  localparam int AXIS_IN_COUNT = 4;    // axes carried by one snapshot
  localparam int INDEX_W       = 4;

  localparam logic [VALUE_W-1:0] THRESHOLD_RESET = 16'd328;  // ~0.01 in Q1.15

  localparam logic KIND_BUTTON = 1'b0;
  localparam logic KIND_AXIS   = 1'b1;

  typedef struct packed {
    logic                      hand_id;
    logic [MASK_W-1:0]         buttons_now;
    logic signed [VALUE_W-1:0] axis_zero;
    logic signed [VALUE_W-1:0] axis_one;
    logic signed [VALUE_W-1:0] axis_two;
    logic signed [VALUE_W-1:0] axis_three;
  } snapshot_t;

  typedef struct packed {
    logic                      event_hand;
    logic                      event_kind;
    logic [INDEX_W-1:0]        event_index;
    logic                      button_level;
    logic signed [VALUE_W-1:0] axis_new_value;
    logic                      last_event;
  } event_t;

endpackage

@@ rtl/ccd_axis_unit.sv @@
// Shared axis change unit: exact 17-bit difference, magnitude, threshold compare.
module ccd_axis_unit (
  input  logic signed [ccd_pkg::VALUE_W-1:0] value_now,
  input  logic signed [ccd_pkg::VALUE_W-1:0] value_old,
  input  logic        [ccd_pkg::VALUE_W-1:0] threshold,
  output logic                               exceeds
);

  logic signed [ccd_pkg::VALUE_W:0] diff;
  logic signed [ccd_pkg::VALUE_W:0] diff_neg;
  logic        [ccd_pkg::VALUE_W-1:0] mag;

  always_comb begin
    diff     = {value_now[ccd_pkg::VALUE_W-1], value_now}
             - {value_old[ccd_pkg::VALUE_W-1], value_old};
    diff_neg = -diff;
    // |diff| never exceeds 65535, so the low 16 bits hold it exactly
    mag      = diff[ccd_pkg::VALUE_W] ? diff_neg[ccd_pkg::VALUE_W-1:0]
                                      : diff[ccd_pkg::VALUE_W-1:0];
    exceeds  = mag > threshold;
  end

endmodule

@@ rtl/controller_change_event_detector.sv @@
// Controller change event detector: top level with scan sequencer and state store.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------
//  snap    | in        | snap_valid/stall    | ccd_pkg::snapshot_t
//  evt     | out       | evt_valid/stall     | ccd_pkg::event_t
//  cfg     | in        | cfg_valid/ready     | 16-bit axis change threshold
//
// A snapshot takes one scan step per button (at most 16) and per axis, the
// axes through the single axis compare unit, then a flush of the held event.
// Each scan step waits while the output register is full and stalled.
// snap_stall is high from acceptance until the flush; the output register
// still drains while the next snapshot is taken. Synchronous reset clears the
// stored masks and axes to zero and the threshold to 328.
module controller_change_event_detector #(
  parameter int BUTTON_COUNT = 16,
  parameter int AXIS_COUNT   = 4,
  parameter int HAND_COUNT   = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              snap_valid,
  output logic                              snap_stall,
  input  ccd_pkg::snapshot_t                snap,
  output logic                              evt_valid,
  input  logic                              evt_stall,
  output ccd_pkg::event_t                   evt,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ccd_pkg::VALUE_W-1:0]       cfg_data
);

  // buttons above the 16-bit mask read as released and never change
  localparam int BTN_SCAN = (BUTTON_COUNT < ccd_pkg::MASK_W) ? BUTTON_COUNT
                                                             : ccd_pkg::MASK_W;
  localparam int HIDX_W   = (HAND_COUNT > 1) ? $clog2(HAND_COUNT) : 1;
  localparam int AX_W     = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam int PA_DEPTH = HAND_COUNT * AXIS_COUNT;
  localparam int PA_W     = (PA_DEPTH > 1) ? $clog2(PA_DEPTH) : 1;

  typedef enum logic [1:0] {IDLE, SCAN, FLUSH} state_t;

  state_t state;

  // per-hand stored state
  logic        [ccd_pkg::MASK_W-1:0]  prev_buttons [HAND_COUNT];
  logic signed [ccd_pkg::VALUE_W-1:0] prev_axes    [PA_DEPTH];

  // current snapshot under scan
  logic                               hand;
  logic        [ccd_pkg::MASK_W-1:0]  buttons;
  logic        [ccd_pkg::MASK_W-1:0]  diff;
  logic signed [ccd_pkg::VALUE_W-1:0] axes [AXIS_COUNT];
  logic                               axis_phase;
  logic        [ccd_pkg::INDEX_W-1:0] idx;

  // one event held back until we know whether another follows
  logic                               pend_valid;
  ccd_pkg::event_t                    pend;

  logic                               out_valid;
  ccd_pkg::event_t                    out;
  logic        [ccd_pkg::VALUE_W-1:0] threshold;

  // combinational
  logic signed [ccd_pkg::VALUE_W-1:0] snap_axes [AXIS_COUNT];
  logic                               hand_ok;
  logic        [HIDX_W-1:0]           snap_hidx;
  logic        [AX_W-1:0]             ax_idx;
  logic        [PA_W-1:0]             pa_idx;
  logic                               exceeds;
  logic                               cand_found;
  ccd_pkg::event_t                    cand;
  ccd_pkg::event_t                    pend_last;
  logic                               step_last;
  logic                               out_free;
  logic                               out_load;

  always_comb begin
    for (int i = 0; i < AXIS_COUNT; i++) begin
      case (i)
        0:       snap_axes[i] = snap.axis_zero;
        1:       snap_axes[i] = snap.axis_one;
        2:       snap_axes[i] = snap.axis_two;
        3:       snap_axes[i] = snap.axis_three;
        default: snap_axes[i] = '0;   // axes beyond the snapshot read as zero
      endcase
    end
  end

  assign hand_ok   = (HAND_COUNT > 1) || !snap.hand_id;
  assign snap_hidx = HIDX_W'(snap.hand_id);
  assign ax_idx    = idx[AX_W-1:0];
  assign pa_idx    = PA_W'(int'(hand) * AXIS_COUNT + int'(ax_idx));
  assign out_free  = !out_valid || !evt_stall;
  // output register takes the held event this cycle
  assign out_load  = out_free && pend_valid
                   && (((state == SCAN) && cand_found) || (state == FLUSH));

  ccd_axis_unit u_axis (
    .value_now (axes[ax_idx]),
    .value_old (prev_axes[pa_idx]),
    .threshold (threshold),
    .exceeds   (exceeds)
  );

  always_comb begin
    cand_found          = axis_phase ? exceeds : diff[idx];
    cand.event_hand     = hand;
    cand.event_kind     = axis_phase ? ccd_pkg::KIND_AXIS : ccd_pkg::KIND_BUTTON;
    cand.event_index    = idx;
    cand.button_level   = axis_phase ? 1'b0 : buttons[idx];
    cand.axis_new_value = axis_phase ? axes[ax_idx] : '0;
    cand.last_event     = 1'b0;
    step_last           = axis_phase
                        ? (idx == ccd_pkg::INDEX_W'(AXIS_COUNT - 1))
                        : (idx == ccd_pkg::INDEX_W'(BTN_SCAN - 1));
    // held event marked as the final one of its snapshot
    pend_last            = pend;
    pend_last.last_event = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      threshold  <= ccd_pkg::THRESHOLD_RESET;
      for (int h = 0; h < HAND_COUNT; h++) begin
        prev_buttons[h] <= '0;
      end
      for (int a = 0; a < PA_DEPTH; a++) begin
        prev_axes[a] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        threshold <= cfg_data;
      end
      if (out_valid && !evt_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          // out-of-range hands are taken and dropped
          if (snap_valid && hand_ok) begin
            hand                    <= snap.hand_id;
            buttons                 <= snap.buttons_now;
            diff                    <= snap.buttons_now ^ prev_buttons[snap_hidx];
            prev_buttons[snap_hidx] <= snap.buttons_now;
            for (int i = 0; i < AXIS_COUNT; i++) begin
              axes[i] <= snap_axes[i];
            end
            axis_phase <= 1'b0;
            idx        <= '0;
            state      <= SCAN;
          end
        end
        SCAN: begin
          if (out_free) begin
            if (cand_found) begin
              if (pend_valid) begin
                out       <= pend;
                out_valid <= 1'b1;
              end
              pend       <= cand;
              pend_valid <= 1'b1;
            end
            if (axis_phase) begin
              prev_axes[pa_idx] <= axes[ax_idx];
            end
            if (step_last) begin
              if (axis_phase) begin
                state <= FLUSH;
              end else begin
                axis_phase <= 1'b1;
                idx        <= '0;
              end
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        FLUSH: begin
          if (!pend_valid) begin
            state <= IDLE;
          end else if (out_free) begin
            out        <= pend_last;
            out_valid  <= 1'b1;
            pend_valid <= 1'b0;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign snap_stall = (state != IDLE);
  assign evt_valid  = out_valid;
  assign evt        = out;
  assign cfg_ready  = 1'b1;

endmodule

@@ rtl/ccd_checker.sv @@
// Port-level checker for the controller change event detector, with its bind.
module ccd_checker #(
  parameter int HAND_COUNT = 2
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        snap_valid,
  input logic                        snap_stall,
  input ccd_pkg::snapshot_t          snap,
  input logic                        evt_valid,
  input logic                        evt_stall,
  input ccd_pkg::event_t             evt,
  input logic                        cfg_valid,
  input logic                        cfg_ready
);

  // held event stays put under stall
  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_stall |=> evt_valid && $stable(evt))
    else $error("event changed while stalled");

  // a taken snapshot for a live hand keeps the block busy next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    snap_valid && !snap_stall && ((HAND_COUNT > 1) || !snap.hand_id) |=> snap_stall)
    else $error("snapshot not held busy");

  // more events of the snapshot are still to come behind a non-final one
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt.last_event |-> snap_stall)
    else $error("non-final event while idle");

  // unused payload fields are zero for each kind
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    evt_valid |-> (evt.event_kind == ccd_pkg::KIND_BUTTON && evt.axis_new_value == '0)
               || (evt.event_kind == ccd_pkg::KIND_AXIS && !evt.button_level))
    else $error("stray payload bits in event");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("threshold write refused");

endmodule

bind controller_change_event_detector ccd_checker #(.HAND_COUNT(HAND_COUNT)) u_ccd_checker (
  .clk        (clk),
  .rst        (rst),
  .snap_valid (snap_valid),
  .snap_stall (snap_stall),
  .snap       (snap),
  .evt_valid  (evt_valid),
  .evt_stall  (evt_stall),
  .evt        (evt),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
